FILE: hdl/tpgb_pkg.sv
package tpgb_pkg;

    localparam int PLANES     = 32;
    localparam int MAX_PIXELS = 65536;
    localparam int TAPS       = 4;

    localparam int PIX_W    = 32;
    localparam int STRIDE_W = 4;
    localparam int SHIFT_W  = 5;
    localparam int FRAME_W  = 17;
    localparam int ADDR_W   = 4;

    localparam int PLANE_W = (PLANES > 1) ? $clog2(PLANES) : 1;
    localparam int POS_W   = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int LEN_W   = POS_W + 1;

    localparam logic [STRIDE_W-1:0] STRIDE_RST = 4'd8;
    localparam logic [PIX_W-1:0]    MASK_RST   = 32'h00fc_fcfc;
    localparam logic [SHIFT_W-1:0]  SHIFT_RST  = 5'd2;
    localparam logic [FRAME_W-1:0]  FRAME_RST  = 17'd65536;

    typedef enum logic [1:0] {
        REG_STRIDE,
        REG_MASK,
        REG_SHIFT,
        REG_FRAME
    } reg_idx_t;

    typedef logic [PIX_W-1:0]   pix_t;
    typedef logic [PLANE_W-1:0] plane_t;
    typedef logic [POS_W-1:0]   pos_t;

    typedef struct packed {
        logic [STRIDE_W-1:0] stride;
        pix_t                mask;
        logic [SHIFT_W-1:0]  shift;
        logic [FRAME_W-1:0]  frame;
    } cfg_t;

    // request leaving the sequencer, one per accepted pixel
    typedef struct packed {
        logic                  valid;
        pos_t                  pos;
        plane_t                cur;
        plane_t [TAPS-1:0]     taps;
        pix_t                  spx;
        logic                  last;
    } issue_t;

    typedef struct packed {
        logic en;
        logic s1_valid;
        pos_t s1_pos;
        logic s2_valid;
        pos_t s2_pos;
    } pipe_view_t;

    typedef struct packed {
        logic busy;
        pos_t addr;
    } clear_t;

    function automatic pix_t scale(pix_t v, pix_t mask, logic [SHIFT_W-1:0] sh);
        return (v & mask) >> sh;
    endfunction

endpackage

FILE: hdl/tpgb_ram.sv
module tpgb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/tpgb_seq.sv
module tpgb_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tpgb_pkg::cfg_t       cfg,
    input  logic                 frame_wr,
    input  logic                 pix_valid,
    input  tpgb_pkg::pix_t       pixel_in,
    output logic                 pix_stall,
    input  tpgb_pkg::pipe_view_t view,
    output tpgb_pkg::issue_t     issue,
    output tpgb_pkg::clear_t     clr
);
    import tpgb_pkg::*;

    pos_t                pos_reg, pos_next, pos;
    plane_t              cur_reg, cur_next, base;
    logic [LEN_W-1:0]    len, pos_inc;
    logic [STRIDE_W-1:0] base_mask;
    logic                hazard, accept, last;
    logic                clr_busy_reg, clr_busy_next;
    pos_t                clr_addr_reg, clr_addr_next;

    always_comb
    begin
        if (cfg.frame == '0)
        begin
            len = LEN_W'(1);
        end
        else if (cfg.frame > FRAME_W'(MAX_PIXELS))
        begin
            len = LEN_W'(MAX_PIXELS);
        end
        else
        begin
            len = LEN_W'(cfg.frame);
        end
    end

    assign pos     = ({1'b0, pos_reg} >= len) ? '0 : pos_reg;
    assign pos_inc = {1'b0, pos} + LEN_W'(1);
    assign last    = (pos_inc >= len);

    // a pixel waits while an older one at the same position has not yet written back
    assign hazard    = (view.s1_valid && (view.s1_pos == pos)) ||
                       (view.s2_valid && (view.s2_pos == pos));
    assign pix_stall = clr_busy_reg || !view.en || hazard;
    assign accept    = pix_valid && !pix_stall;

    assign base_mask = cfg.stride - STRIDE_W'(1);
    assign base      = cur_reg & PLANE_W'(base_mask);

    always_comb
    begin
        issue.valid = accept;
        issue.pos   = pos;
        issue.cur   = cur_reg;
        issue.spx   = scale(pixel_in, cfg.mask, cfg.shift);
        issue.last  = last;
        for (int k = 0; k < TAPS; k++)
        begin
            issue.taps[k] = base + plane_t'(k) * plane_t'(cfg.stride);
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        cur_next = cur_reg;
        if (frame_wr)
        begin
            pos_next = '0;
            cur_next = '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                pos_next = '0;
                cur_next = cur_reg + PLANE_W'(1);
            end
            else
            begin
                pos_next = pos_t'(pos_inc);
            end
        end
    end

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + POS_W'(1);
            if (clr_addr_reg == pos_t'(MAX_PIXELS - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            cur_reg      <= '0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            cur_reg      <= cur_next;
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    assign clr.busy = clr_busy_reg;
    assign clr.addr = clr_addr_reg;

endmodule

FILE: hdl/tpgb_blend.sv
module tpgb_blend (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tpgb_pkg::cfg_t       cfg,
    input  tpgb_pkg::issue_t     issue,
    input  tpgb_pkg::clear_t     clr,
    output tpgb_pkg::pipe_view_t view,
    output logic                 res_valid,
    input  logic                 res_stall,
    output tpgb_pkg::pix_t       pixel_out,
    output logic                 frame_end
);
    import tpgb_pkg::*;

    typedef struct packed {
        logic              valid;
        pos_t              pos;
        plane_t            cur;
        logic              last;
        pix_t [TAPS-1:0]   ops;
    } s2_t;

    typedef struct packed {
        logic   valid;
        pos_t   pos;
        plane_t cur;
        logic   last;
        pix_t   sum;
    } s3_t;

    typedef struct packed {
        logic   valid;
        pos_t   pos;
        plane_t plane;
        pix_t   data;
    } wb_t;

    issue_t s1_reg, s1_next;
    s2_t    s2_reg, s2_next;
    s3_t    s3_reg, s3_next;
    wb_t    lw_reg, lw_next;

    logic              en, wr_pipe;
    logic [PLANES-1:0] wr_en;
    pos_t              wr_addr;
    pix_t              wr_data, s3_scaled, sum;
    pix_t              rd_data [PLANES];

    assign en        = !(s3_reg.valid && res_stall);
    assign wr_pipe   = s3_reg.valid && en;
    assign s3_scaled = scale(s3_reg.sum, cfg.mask, cfg.shift);
    assign wr_addr   = clr.busy ? clr.addr : s3_reg.pos;
    assign wr_data   = clr.busy ? '0 : s3_scaled;

    for (genvar i = 0; i < PLANES; i++)
    begin : g_plane
        assign wr_en[i] = clr.busy || (wr_pipe && (s3_reg.cur == plane_t'(i)));

        tpgb_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_PIXELS)
        ) u_ram (
            .clk     (clk),
            .wr_en   (wr_en[i]),
            .wr_addr (wr_addr),
            .wr_data (wr_data),
            .rd_en   (en),
            .rd_addr (issue.pos),
            .rd_data (rd_data[i])
        );
    end

    assign s1_next = issue;

    // own plane holds the fresh pixel; the write-back landing with the read is bypassed
    always_comb
    begin
        s2_next.valid = s1_reg.valid;
        s2_next.pos   = s1_reg.pos;
        s2_next.cur   = s1_reg.cur;
        s2_next.last  = s1_reg.last;
        for (int k = 0; k < TAPS; k++)
        begin
            if (s1_reg.taps[k] == s1_reg.cur)
            begin
                s2_next.ops[k] = s1_reg.spx;
            end
            else if (lw_reg.valid && (lw_reg.pos == s1_reg.pos) &&
                     (lw_reg.plane == s1_reg.taps[k]))
            begin
                s2_next.ops[k] = lw_reg.data;
            end
            else
            begin
                s2_next.ops[k] = rd_data[s1_reg.taps[k]];
            end
        end
    end

    always_comb
    begin
        sum = '0;
        for (int k = 0; k < TAPS; k++)
        begin
            sum = sum + s2_reg.ops[k];
        end
        s3_next.valid = s2_reg.valid;
        s3_next.pos   = s2_reg.pos;
        s3_next.cur   = s2_reg.cur;
        s3_next.last  = s2_reg.last;
        s3_next.sum   = sum;
    end

    always_comb
    begin
        lw_next.valid = s3_reg.valid;
        lw_next.pos   = s3_reg.pos;
        lw_next.plane = s3_reg.cur;
        lw_next.data  = s3_scaled;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
            lw_reg <= '0;
        end
        else if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            lw_reg <= lw_next;
        end
    end

    assign view.en       = en;
    assign view.s1_valid = s1_reg.valid;
    assign view.s1_pos   = s1_reg.pos;
    assign view.s2_valid = s2_reg.valid;
    assign view.s2_pos   = s2_reg.pos;

    assign res_valid = s3_reg.valid;
    assign pixel_out = s3_reg.sum;
    assign frame_end = s3_reg.last;

endmodule

FILE: hdl/temporal_plane_ghost_blend.sv
// Pipeline: an accepted request passes through the s1, s2 and s3 registers; its result
// is valid from s3 and is held there while res_stall is high.
// Throughput: one pixel per cycle unless res_stall, the memory clear or a position hazard
// holds it; frames of one or two pixels are slower, since a pixel waits for the write-back
// of its position. Reset: registers return to defaults and plane and position counters
// clear; then a sweep zeroes the plane memories, one position per cycle over every position,
// during which pix_stall is high. Configuration writes are taken throughout.
module temporal_plane_ghost_blend (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpgb_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          pix_valid,
    output logic                          pix_stall,
    input  logic [31:0]                   pixel_in,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [31:0]                   pixel_out,
    output logic                          frame_end
);
    import tpgb_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    reg_idx_t   idx;
    logic       wr, frame_wr;
    issue_t     issue;
    clear_t     clr;
    pipe_view_t view;

    assign pready   = 1'b1;
    assign wr       = psel && penable && pwrite && pready;
    assign idx      = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign frame_wr = wr && (idx == REG_FRAME);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (idx)
                REG_STRIDE: cfg_next.stride = pwdata[STRIDE_W-1:0];
                REG_MASK:   cfg_next.mask   = pwdata[PIX_W-1:0];
                REG_SHIFT:  cfg_next.shift  = pwdata[SHIFT_W-1:0];
                REG_FRAME:  cfg_next.frame  = pwdata[FRAME_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_STRIDE: prdata = 32'(cfg_reg.stride);
            REG_MASK:   prdata = 32'(cfg_reg.mask);
            REG_SHIFT:  prdata = 32'(cfg_reg.shift);
            REG_FRAME:  prdata = 32'(cfg_reg.frame);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stride <= STRIDE_RST;
            cfg_reg.mask   <= MASK_RST;
            cfg_reg.shift  <= SHIFT_RST;
            cfg_reg.frame  <= FRAME_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tpgb_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .frame_wr  (frame_wr),
        .pix_valid (pix_valid),
        .pixel_in  (pixel_in),
        .pix_stall (pix_stall),
        .view      (view),
        .issue     (issue),
        .clr       (clr)
    );

    tpgb_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .issue     (issue),
        .clr       (clr),
        .view      (view),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .pixel_out (pixel_out),
        .frame_end (frame_end)
    );

    a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr.busy |-> !(pix_valid && !pix_stall))
        else $error("request accepted during memory clear");

    a_no_same_pos_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (view.s1_valid && view.s2_valid) |-> (view.s1_pos != view.s2_pos))
        else $error("two in-flight requests share a position");

    a_clear_full_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clr.busy) |-> ($past(clr.addr) == pos_t'(MAX_PIXELS - 1)))
        else $error("memory clear ended early");

    a_issue_only_when_advancing: assert property (@(posedge clk) disable iff (!rst_n)
        issue.valid |-> view.en)
        else $error("request issued while pipeline held");

endmodule

FILE: dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tpgb_pkg::*;

    localparam int STUCK_LIMIT = 200000;
    localparam int MAX_SHOWN   = 10;

    typedef struct {
        pix_t pixel;
        logic last;
    } blend_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [ADDR_W-1:0]   paddr     = '0;
    logic [31:0]         pwdata    = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                pix_valid = 1'b0;
    logic                pix_stall;
    logic [31:0]         pixel_in  = '0;
    logic                res_valid;
    logic                res_stall = 1'b0;
    logic [31:0]         pixel_out;
    logic                frame_end;

    // shadow of the block: registers, counters and plane memory
    logic [STRIDE_W-1:0] cfg_stride = STRIDE_RST;
    pix_t                cfg_mask   = MASK_RST;
    logic [SHIFT_W-1:0]  cfg_shift  = SHIFT_RST;
    logic [FRAME_W-1:0]  cfg_frame  = FRAME_RST;
    plane_t              cur_plane  = '0;
    int unsigned         pix_pos    = 0;
    pix_t                plane_mem [logic [PLANE_W+POS_W-1:0]];

    blend_t              blend_q [$];
    int unsigned         mismatch_count = 0;
    int unsigned         stuck_cycles   = 0;
    bit                  src_gaps  = 1'b1;
    bit                  sink_gaps = 1'b1;

    temporal_plane_ghost_blend dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pixel_in  (pixel_in),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .pixel_out (pixel_out),
        .frame_end (frame_end)
    );

    always #2 clk = ~clk;

    function automatic void flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    function automatic pix_t mem_read(input plane_t pl, input pos_t pos);
        if (plane_mem.exists({pl, pos}))
            return plane_mem[{pl, pos}];
        return '0;
    endfunction

    function automatic pix_t scale_word(input pix_t v);
        return (v & cfg_mask) >> cfg_shift;
    endfunction

    function automatic void predict_blend(input pix_t px);
        int unsigned         flen;
        pos_t                pos;
        logic [STRIDE_W-1:0] base_mask;
        plane_t              base;
        plane_t              tap;
        pix_t                sum;
        blend_t              want;
        flen = (cfg_frame == 0) ? 1 :
               ((cfg_frame > MAX_PIXELS) ? MAX_PIXELS : int'(cfg_frame));
        pos = (pix_pos >= flen) ? '0 : pos_t'(pix_pos);
        plane_mem[{cur_plane, pos}] = scale_word(px);
        base_mask = cfg_stride - 1'b1;
        base = cur_plane & plane_t'(base_mask);
        sum = '0;
        for (int k = 0; k < TAPS; k++)
        begin
            tap = base + plane_t'(k * int'(cfg_stride));
            sum = sum + mem_read(tap, pos);
        end
        plane_mem[{cur_plane, pos}] = scale_word(sum);
        want.pixel = sum;
        want.last = (int'(pos) + 1 >= flen);
        if (want.last)
        begin
            pix_pos = 0;
            cur_plane = cur_plane + 1'b1;
        end
        else
            pix_pos = int'(pos) + 1;
        blend_q.push_back(want);
    endfunction

    function automatic pix_t rand_pixel();
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_pixel(input pix_t px);
        bit taken;
        while (src_gaps && $urandom_range(99) < 23)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pixel_in  <= px;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !pix_stall;
            if (taken)
                predict_blend(px);
            @(posedge clk);
        end
    endtask

    task automatic wait_drain();
        pix_valid <= 1'b0;
        while (blend_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
        begin
            @(posedge clk);
            @(negedge clk);
        end
        case (idx)
            REG_STRIDE: cfg_stride = val[STRIDE_W-1:0];
            REG_MASK:   cfg_mask   = val;
            REG_SHIFT:  cfg_shift  = val[SHIFT_W-1:0];
            REG_FRAME:
            begin
                cfg_frame = val[FRAME_W-1:0];
                cur_plane = '0;
                pix_pos   = 0;
            end
        endcase
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] stride, input logic [31:0] mask,
                              input logic [31:0] shift, input logic [31:0] frame);
        write_reg(REG_STRIDE, stride);
        write_reg(REG_MASK, mask);
        write_reg(REG_SHIFT, shift);
        write_reg(REG_FRAME, frame);
    endtask

    task automatic test_reset_defaults();
        send_pixel('0);
        send_pixel('1);
        send_pixel(32'ha5a5_a5a5);
        send_pixel(32'h5a5a_5a5a);
        wait_drain();
    endtask

    // zero acts as one pixel, oversize clamps to the plane depth
    task automatic test_frame_extremes();
        write_reg(REG_FRAME, 32'd0);
        repeat (3) send_pixel(rand_pixel());
        wait_drain();
        write_reg(REG_FRAME, 32'd2);
        repeat (3) send_pixel(rand_pixel());
        wait_drain();
        write_reg(REG_FRAME, 32'h1_ffff);
        repeat (2) send_pixel(rand_pixel());
        wait_drain();
        write_reg(REG_FRAME, 32'd65536);
        send_pixel('1);
        wait_drain();
    endtask

    // stride zero: all four taps land on the base plane
    task automatic test_stride_zero();
        set_config(32'd0, MASK_RST, SHIFT_RST, 32'd1);
        repeat (3) send_pixel(rand_pixel());
        wait_drain();
    endtask

    task automatic test_mask_shift();
        set_config(32'd1, 32'hffff_ffff, 32'd0, 32'd1);
        send_pixel('1);
        send_pixel(32'h8000_0001);
        send_pixel('1);
        wait_drain();
        set_config(32'd15, 32'h0, 32'd31, 32'd2);
        send_pixel('1);
        send_pixel(32'h1234_5678);
        wait_drain();
    endtask

    // one-pixel frames walk the ring past its end; odd stride wraps the taps
    task automatic test_ring_wrap();
        set_config(32'd15, 32'hffff_ffff, 32'd1, 32'd1);
        repeat (40) send_pixel(rand_pixel());
        wait_drain();
    endtask

    task automatic test_random_mix();
        logic [31:0] mask;
        logic [31:0] frame;
        for (int ph = 0; ph < 8; ph++)
        begin
            src_gaps  = (ph != 3);
            sink_gaps = (ph != 3);
            case ($urandom_range(7))
                0:       mask = '0;
                1:       mask = '1;
                2:       mask = MASK_RST;
                default: mask = $urandom();
            endcase
            case ($urandom_range(9))
                0:       frame = 32'd0;
                1:       frame = (ph < 2) ? 32'd1 : 32'h1_ffff;
                2:       frame = (ph < 2) ? 32'd2 : 32'd65536;
                default: frame = $urandom_range(1, 6);
            endcase
            set_config($urandom_range(15), mask, $urandom_range(31), frame);
            repeat (110)
            begin
                if ($urandom_range(99) == 0)
                    wait_drain();
                send_pixel(rand_pixel());
            end
            wait_drain();
        end
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
    endtask

    always @(posedge clk)
        res_stall <= sink_gaps && ($urandom_range(99) < 23);

    always @(negedge clk)
    begin : result_check
        blend_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (blend_q.size() == 0)
                flag_error($sformatf("result %h/%b with nothing pending",
                                     pixel_out, frame_end));
            else
            begin
                want = blend_q.pop_front();
                if (pixel_out !== want.pixel || frame_end !== want.last)
                    flag_error($sformatf("pixel_out exp %h got %h, frame_end exp %b got %b",
                                         want.pixel, pixel_out, want.last, frame_end));
            end
        end
        if ((pix_valid && !pix_stall) || (res_valid && !res_stall) || (psel && penable))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STUCK_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_frame_extremes();
        test_stride_zero();
        test_mask_shift();
        test_ring_wrap();
        test_random_mix();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && blend_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
hdl/tpgb_pkg.sv
hdl/tpgb_ram.sv
hdl/tpgb_seq.sv
hdl/tpgb_blend.sv
hdl/temporal_plane_ghost_blend.sv
dv/tb_top.sv
